>>> hdl/alarm_timer_table_top_assert.svh
// Assertion macros for the alarm timer table.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ALARM_TIMER_TABLE_TOP_ASSERT_SVH
`define ALARM_TIMER_TABLE_TOP_ASSERT_SVH

// The condition holds at every clock edge.
`define ATT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ATT_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ATT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/att_pkg.sv
// Shared constants, codes and types for the alarm timer table.
// Used by att_alu, alarm_timer_table_top and the testbench; it depends on nothing else.
`default_nettype none

package att_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int FREE_W     = $clog2(NUM_TIMERS + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

  localparam logic [15:0] IDLE_WAIT_RESET = 16'd50;

  localparam logic [1:0] KIND_SET      = 2'd0;
  localparam logic [1:0] KIND_DELETE   = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;

  localparam logic [2:0] RK_SET_OK  = 3'd0;
  localparam logic [2:0] RK_FULL    = 3'd1;
  localparam logic [2:0] RK_DELETED = 3'd2;
  localparam logic [2:0] RK_BAD     = 3'd3;
  localparam logic [2:0] RK_FIRED   = 3'd4;
  localparam logic [2:0] RK_WAIT    = 3'd5;

  localparam logic [4:0] HANDLE_NONE    = 5'h1F;
  localparam logic [8:0] SLOT_HANDLE_NONE = 9'h1FF;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [31:0] y;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        borrow;
    logic        lt;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> hdl/att_alu.sv
// Shared 32-bit add/subtract and less-than unit of the alarm timer table.
// Depends on att_pkg for the request and response types.
`default_nettype none

module att_alu (
  input  att_pkg::alu_req_t req,
  output att_pkg::alu_rsp_t rsp
);

  logic [32:0] sum;

  always_comb begin
    if (req.op == att_pkg::ALU_SUB) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign rsp.res    = sum[31:0];
  assign rsp.borrow = (req.op == att_pkg::ALU_SUB) & sum[32];
  assign rsp.lt     = req.x < req.y;

endmodule

`default_nettype wire

>>> hdl/alarm_timer_table_top.sv
// Top level of the alarm timer table: sequencer, slot storage and result register.
// Depends on att_pkg, att_alu and the assertion macros in alarm_timer_table_top_assert.svh.
`default_nettype none

// The table holds att_pkg::NUM_TIMERS alarm slots, walked one slot per cycle by a
// slot counter that drives a single slot read port and one shared adder. A request
// is taken only while the block is idle. A delete is decided in the ST_DEL state; a
// set walks the slots up to the lowest free one, or up to the last slot when the
// table is full. A dispatch first scans all N slots, then either reports the wait or
// walks the slots up to the last expired one. Any step that emits a result, a
// walked slot included, waits while the result register is held by out_stall.
// Result fields are registered; free_slots on every result gives the count after
// the whole request.

module alarm_timer_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [31:0]        now,
  input  logic [31:0]        alarm_id,
  input  logic [31:0]        delay,
  input  logic [31:0]        period,
  input  logic signed [8:0]  slot_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         result_kind,
  output logic signed [4:0]  handle,
  output logic [31:0]        fired_id,
  output logic [31:0]        wait_time,
  output logic [4:0]         free_slots,
  output logic               last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SET  = 3'd1;
  localparam logic [2:0] ST_DEL  = 3'd2;
  localparam logic [2:0] ST_DISP = 3'd3;
  localparam logic [2:0] ST_DEND = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_FIRE = 3'd6;

  logic [2:0]                     state;
  logic [att_pkg::IDX_W-1:0]      idx;
  logic [att_pkg::IDX_W-1:0]      last_exp;
  logic [att_pkg::FREE_W-1:0]     free_cnt;
  logic [att_pkg::FREE_W-1:0]     freed;
  logic [att_pkg::NUM_TIMERS-1:0] armed;
  logic [att_pkg::NUM_TIMERS-1:0] exp_vec;
  logic                           any_exp;
  logic                           have_near;
  logic [31:0]                    nearest;
  logic [15:0]                    idle_wait;

  logic [31:0] req_now;
  logic [31:0] req_id;
  logic [31:0] req_delay;
  logic [31:0] req_period;
  logic [8:0]  req_handle;

  logic [31:0] slot_expiry [att_pkg::NUM_TIMERS];
  logic [31:0] slot_period [att_pkg::NUM_TIMERS];
  logic [31:0] slot_id     [att_pkg::NUM_TIMERS];

  att_pkg::alu_req_t alu_req;
  att_pkg::alu_rsp_t alu_rsp;

  logic                      out_free;
  logic                      del_none;
  logic                      del_bad;
  logic [att_pkg::IDX_W-1:0] del_idx;

  logic        emit;
  logic [2:0]  e_kind;
  logic [4:0]  e_handle;
  logic [31:0] e_id;
  logic [31:0] e_wait;
  logic [4:0]  e_free;
  logic        e_last;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign del_none = (req_handle == att_pkg::SLOT_HANDLE_NONE);
  assign del_bad  = req_handle[8] || (req_handle >= 9'(att_pkg::NUM_TIMERS));
  assign del_idx  = req_handle[att_pkg::IDX_W-1:0];

  att_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    alu_req.op = att_pkg::ALU_ADD;
    alu_req.a  = req_now;
    alu_req.b  = req_delay;
    alu_req.x  = slot_expiry[idx];
    alu_req.y  = nearest;
    case (state)
      ST_DISP: begin
        alu_req.op = att_pkg::ALU_SUB;
        alu_req.b  = slot_expiry[idx];
      end
      ST_FIRE: begin
        alu_req.b  = slot_period[idx];
      end
      ST_WAIT: begin
        alu_req.op = att_pkg::ALU_SUB;
        alu_req.a  = nearest;
        alu_req.b  = req_now;
      end
      default: begin
        alu_req.op = att_pkg::ALU_ADD;
      end
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    e_kind   = att_pkg::RK_SET_OK;
    e_handle = att_pkg::HANDLE_NONE;
    e_id     = 32'd0;
    e_wait   = 32'd0;
    e_free   = 5'(free_cnt);
    e_last   = 1'b1;
    case (state)
      ST_SET: begin
        if (!armed[idx]) begin
          emit     = out_free;
          e_handle = 5'(idx);
          e_free   = 5'(free_cnt - 1'b1);
        end else if (idx == att_pkg::IDX_LAST) begin
          emit   = out_free;
          e_kind = att_pkg::RK_FULL;
        end
      end
      ST_DEL: begin
        emit   = out_free;
        e_kind = att_pkg::RK_DELETED;
        if (del_none) begin
          e_kind = att_pkg::RK_DELETED;
        end else if (del_bad) begin
          e_kind = att_pkg::RK_BAD;
        end else begin
          e_handle = 5'(del_idx);
          e_free   = 5'(free_cnt + att_pkg::FREE_W'(armed[del_idx]));
        end
      end
      ST_WAIT: begin
        emit   = out_free;
        e_kind = att_pkg::RK_WAIT;
        e_wait = have_near ? alu_rsp.res : 32'(idle_wait);
      end
      ST_FIRE: begin
        if (exp_vec[idx]) begin
          emit     = out_free;
          e_kind   = att_pkg::RK_FIRED;
          e_handle = 5'(idx);
          e_id     = slot_id[idx];
          e_wait   = 32'd1;
          e_last   = (idx == last_exp);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      last_exp  <= '0;
      free_cnt  <= att_pkg::FREE_W'(att_pkg::NUM_TIMERS);
      freed     <= '0;
      armed     <= '0;
      exp_vec   <= '0;
      any_exp   <= 1'b0;
      have_near <= 1'b0;
      idle_wait <= att_pkg::IDLE_WAIT_RESET;
    end else begin
      if (cfg_write) begin
        idle_wait <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            idx       <= '0;
            exp_vec   <= '0;
            any_exp   <= 1'b0;
            have_near <= 1'b0;
            freed     <= '0;
            case (kind)
              att_pkg::KIND_SET:      state <= ST_SET;
              att_pkg::KIND_DELETE:   state <= ST_DEL;
              att_pkg::KIND_DISPATCH: state <= ST_DISP;
              default:                state <= ST_IDLE;
            endcase
          end
        end
        ST_SET: begin
          if (!armed[idx]) begin
            if (out_free) begin
              armed[idx] <= 1'b1;
              free_cnt   <= free_cnt - 1'b1;
              state      <= ST_IDLE;
            end
          end else if (idx == att_pkg::IDX_LAST) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DEL: begin
          if (out_free) begin
            if (!del_none && !del_bad && armed[del_idx]) begin
              armed[del_idx] <= 1'b0;
              free_cnt       <= free_cnt + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_DISP: begin
          if (armed[idx]) begin
            if (!alu_rsp.borrow) begin
              exp_vec[idx] <= 1'b1;
              any_exp      <= 1'b1;
              last_exp     <= idx;
              if (slot_period[idx] == 32'd0) begin
                freed <= freed + 1'b1;
              end
            end else if (!have_near || alu_rsp.lt) begin
              have_near <= 1'b1;
            end
          end
          if (idx == att_pkg::IDX_LAST) begin
            state <= ST_DEND;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DEND: begin
          idx <= '0;
          if (any_exp) begin
            free_cnt <= free_cnt + freed;
            state    <= ST_FIRE;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_FIRE: begin
          if (exp_vec[idx]) begin
            if (out_free) begin
              if (slot_period[idx] == 32'd0) begin
                armed[idx] <= 1'b0;
              end
              if (idx == last_exp) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_now    <= now;
      req_id     <= alarm_id;
      req_delay  <= delay;
      req_period <= period;
      req_handle <= $unsigned(slot_handle);
    end
    if (state == ST_DISP && armed[idx] && alu_rsp.borrow && (!have_near || alu_rsp.lt)) begin
      nearest <= slot_expiry[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SET && !armed[idx] && out_free) begin
      slot_id[idx]     <= req_id;
      slot_expiry[idx] <= alu_rsp.res;
      slot_period[idx] <= req_period;
    end else if (state == ST_FIRE && exp_vec[idx] && out_free &&
                 slot_period[idx] != 32'd0) begin
      slot_expiry[idx] <= alu_rsp.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= e_kind;
      handle      <= $signed(e_handle);
      fired_id    <= e_id;
      wait_time   <= e_wait;
      free_slots  <= e_free;
      last        <= e_last;
    end
  end

`include "alarm_timer_table_top_assert.svh"

  `ATT_ASSERT_ALWAYS(a_free_range, free_cnt <= att_pkg::FREE_W'(att_pkg::NUM_TIMERS), "free count exceeds table size")
  `ATT_ASSERT_IMPLIES(a_free_count, state == ST_IDLE, free_cnt == att_pkg::FREE_W'($countones(~armed)), "free count disagrees with armed slots")
  `ATT_ASSERT_IMPLIES(a_fire_target, state == ST_FIRE, exp_vec[last_exp], "last expired slot not marked during firing")
  `ATT_ASSERT_NEXT(a_last_ends, emit && e_last, state == ST_IDLE, "final result did not end the request")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for alarm_timer_table_top: a directed table followed by
// random phases, each checked against an alarm table predictor held in this file.
// Depends on att_pkg and the alarm_timer_table_top RTL only.

module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_FIRED = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 65;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic [31:0] alarm_id;
    logic [31:0] delay;
    logic [31:0] period;
    logic [8:0]  slot_handle;
  } alarm_req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [4:0]  handle;
    logic [31:0] fired_id;
    logic [31:0] wait_time;
    logic [4:0]  free_slots;
    logic        last;
  } alarm_result_t;

  typedef struct packed {
    alarm_req_t  req;
    logic [7:0]  count;
    logic        typed;
    logic [2:0]  t_kind;
    logic [4:0]  t_handle;
    logic [31:0] t_wait;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [31:0]        now;
  logic [31:0]        alarm_id;
  logic [31:0]        delay;
  logic [31:0]        period;
  logic signed [8:0]  slot_handle;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         result_kind;
  logic signed [4:0]  handle;
  logic [31:0]        fired_id;
  logic [31:0]        wait_time;
  logic [4:0]         free_slots;
  logic               last;

  logic               typed_check;
  logic [2:0]         typed_kind;
  logic [4:0]         typed_handle;
  logic [31:0]        typed_wait;

  logic               table_armed [att_pkg::NUM_TIMERS];
  logic [31:0]        table_expiry [att_pkg::NUM_TIMERS];
  logic [31:0]        table_period [att_pkg::NUM_TIMERS];
  logic [31:0]        table_id [att_pkg::NUM_TIMERS];
  logic [15:0]        idle_wait_reg;

  alarm_result_t      step_results [$];
  alarm_result_t      pending_results [$];

  int                 errors = 0;
  int                 accepted_count = 0;
  int                 checked_count = 0;
  int                 fired_count = 0;
  int                 full_count = 0;
  int                 idle_pct = 8;
  int                 stall_pct = 8;
  bit                 hold_off_req = 1'b0;
  logic [31:0]        sim_ms = 32'd0;

  directed_row_t directed_rows [24] = '{
    '{'{att_pkg::KIND_DISPATCH, 32'd0, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'(att_pkg::IDLE_WAIT_RESET)},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, att_pkg::SLOT_HANDLE_NONE},
      8'd1, 1'b1, att_pkg::RK_DELETED, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'h1FE}, 8'd1, 1'b1,
      att_pkg::RK_BAD, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'd16}, 8'd1, 1'b1,
      att_pkg::RK_BAD, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'h0FF}, 8'd1, 1'b1,
      att_pkg::RK_BAD, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'h100}, 8'd1, 1'b1,
      att_pkg::RK_BAD, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_DELETED, 5'd0, 32'd0},
    '{'{KIND_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'h1FF},
      8'd1, 1'b0, att_pkg::RK_SET_OK, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_SET, 32'd0, 32'hFFFFFFFF, 32'd100, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_SET_OK, 5'd0, 32'd0},
    '{'{att_pkg::KIND_SET, 32'hFFFFFFF0, 32'h12345678, 32'h20, 32'hFFFFFFFF, 9'd0},
      8'd1, 1'b1, att_pkg::RK_SET_OK, 5'd1, 32'd0},
    '{'{att_pkg::KIND_SET, 32'd0, 32'hA5A5A5A5, 32'hFFFFFFFF, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_SET_OK, 5'd2, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'd5, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'h10, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'hFFFFFFFE, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'd1}, 8'd1, 1'b1,
      att_pkg::RK_DELETED, 5'd1, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'h1000, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'd0, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'(att_pkg::IDLE_WAIT_RESET)},
    '{'{att_pkg::KIND_SET, 32'd7, 32'h0F0F0F0F, 32'd0, 32'd3, 9'd0}, 8'd16, 1'b0,
      att_pkg::RK_SET_OK, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_SET, 32'd0, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_FULL, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DELETE, 32'd0, 32'd0, 32'd0, 32'd0, 9'd15}, 8'd1, 1'b1,
      att_pkg::RK_DELETED, 5'd15, 32'd0},
    '{'{att_pkg::KIND_SET, 32'h80000000, 32'h5A5A5A5A, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b1,
      att_pkg::RK_SET_OK, 5'd15, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'd9, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0},
    '{'{att_pkg::KIND_DISPATCH, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 9'd0}, 8'd1, 1'b0,
      att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0}
  };

  alarm_timer_table_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .now         (now),
    .alarm_id    (alarm_id),
    .delay       (delay),
    .period      (period),
    .slot_handle (slot_handle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .handle      (handle),
    .fired_id    (fired_id),
    .wait_time   (wait_time),
    .free_slots  (free_slots),
    .last        (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_result(input logic [2:0] rk, input logic [4:0] h,
                                     input logic [31:0] id, input logic [31:0] w);
    alarm_result_t res;
    res = '{rk, h, id, w, 5'd0, 1'b0};
    step_results.push_back(res);
  endfunction

  // Applies one request to the predicted alarm table and collects its results.
  function automatic void advance_table(input alarm_req_t r);
    int i;
    int free_slot;
    int free_count;
    logic any_expired;
    logic have_near;
    logic [31:0] nearest;
    step_results.delete();
    free_slot = -1;
    any_expired = 1'b0;
    have_near = 1'b0;
    nearest = 32'd0;
    case (r.kind)
      att_pkg::KIND_SET: begin
        for (i = 0; i < att_pkg::NUM_TIMERS; i++)
          if (!table_armed[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          add_result(att_pkg::RK_FULL, att_pkg::HANDLE_NONE, 32'd0, 32'd0);
        end else begin
          table_armed[free_slot] = 1'b1;
          table_id[free_slot] = r.alarm_id;
          table_expiry[free_slot] = r.now + r.delay;
          table_period[free_slot] = r.period;
          add_result(att_pkg::RK_SET_OK, 5'(free_slot), 32'd0, 32'd0);
        end
      end
      att_pkg::KIND_DELETE: begin
        if (r.slot_handle == att_pkg::SLOT_HANDLE_NONE) begin
          add_result(att_pkg::RK_DELETED, att_pkg::HANDLE_NONE, 32'd0, 32'd0);
        end else if (r.slot_handle[8] || r.slot_handle[7:0] >= att_pkg::NUM_TIMERS) begin
          add_result(att_pkg::RK_BAD, att_pkg::HANDLE_NONE, 32'd0, 32'd0);
        end else begin
          table_armed[r.slot_handle[att_pkg::IDX_W-1:0]] = 1'b0;
          add_result(att_pkg::RK_DELETED, 5'(r.slot_handle[att_pkg::IDX_W-1:0]),
                     32'd0, 32'd0);
        end
      end
      att_pkg::KIND_DISPATCH: begin
        for (i = 0; i < att_pkg::NUM_TIMERS; i++) begin
          if (table_armed[i]) begin
            if (table_expiry[i] <= r.now) begin
              any_expired = 1'b1;
            end else if (!have_near || table_expiry[i] < nearest) begin
              nearest = table_expiry[i];
              have_near = 1'b1;
            end
          end
        end
        if (any_expired) begin
          for (i = 0; i < att_pkg::NUM_TIMERS && step_results.size() < MAX_FIRED; i++) begin
            if (table_armed[i] && table_expiry[i] <= r.now) begin
              add_result(att_pkg::RK_FIRED, 5'(i), table_id[i], 32'd1);
              if (table_period[i] != 32'd0) table_expiry[i] = r.now + table_period[i];
              else table_armed[i] = 1'b0;
            end
          end
        end else if (have_near) begin
          add_result(att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0, nearest - r.now);
        end else begin
          add_result(att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, 32'd0, {16'd0, idle_wait_reg});
        end
      end
      default: begin
      end
    endcase
    free_count = 0;
    for (i = 0; i < att_pkg::NUM_TIMERS; i++)
      if (!table_armed[i]) free_count++;
    foreach (step_results[k]) begin
      step_results[k].free_slots = 5'(free_count);
      step_results[k].last = (k == step_results.size() - 1);
    end
  endfunction

  always @(posedge clk) begin : monitor
    alarm_result_t exp_res;
    alarm_req_t req;
    if (rst) begin
      for (int i = 0; i < att_pkg::NUM_TIMERS; i++) begin
        table_armed[i] = 1'b0;
        table_expiry[i] = 32'd0;
        table_period[i] = 32'd0;
        table_id[i] = 32'd0;
      end
      idle_wait_reg = att_pkg::IDLE_WAIT_RESET;
    end else begin
      if (cfg_write) idle_wait_reg = cfg_data;
      if (in_valid && !in_stall) begin
        req = '{kind, now, alarm_id, delay, period, slot_handle};
        advance_table(req);
        if (typed_check && step_results.size() > 0) begin
          step_results[0].result_kind = typed_kind;
          step_results[0].handle = typed_handle;
          step_results[0].wait_time = typed_wait;
        end
        foreach (step_results[k]) pending_results.push_back(step_results[k]);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: result_kind %0d handle %0h", result_kind, handle);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (result_kind !== exp_res.result_kind) begin
            $error("result_kind: expected %0d, actual %0d", exp_res.result_kind, result_kind);
            errors++;
          end
          if (handle !== exp_res.handle) begin
            $error("handle: expected %0h, actual %0h", exp_res.handle, handle);
            errors++;
          end
          if (fired_id !== exp_res.fired_id) begin
            $error("fired_id: expected %0h, actual %0h", exp_res.fired_id, fired_id);
            errors++;
          end
          if (wait_time !== exp_res.wait_time) begin
            $error("wait_time: expected %0h, actual %0h", exp_res.wait_time, wait_time);
            errors++;
          end
          if (free_slots !== exp_res.free_slots) begin
            $error("free_slots: expected %0d, actual %0d", exp_res.free_slots, free_slots);
            errors++;
          end
          if (last !== exp_res.last) begin
            $error("last: expected %0d, actual %0d", exp_res.last, last);
            errors++;
          end
          checked_count++;
          if (exp_res.result_kind == att_pkg::RK_FIRED) fired_count++;
          if (exp_res.result_kind == att_pkg::RK_FULL) full_count++;
        end
      end
    end
  end

  // The receiver stalls at random, or holds off for a long stretch when asked.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(input alarm_req_t r, input logic tc, input logic [2:0] tk,
                              input logic [4:0] th, input logic [31:0] tw);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    now <= r.now;
    alarm_id <= r.alarm_id;
    delay <= r.delay;
    period <= r.period;
    slot_handle <= r.slot_handle;
    typed_check <= tc;
    typed_kind <= tk;
    typed_handle <= th;
    typed_wait <= tw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors += pending_results.size();
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed traffic on an advancing clock, with some out-of-range noise.
  function automatic alarm_req_t random_request();
    alarm_req_t r;
    int sel;
    r = '{2'($urandom), $urandom, $urandom, $urandom, $urandom, 9'($urandom)};
    sel = $urandom_range(99);
    if (sel < 45) begin
      r.kind = att_pkg::KIND_SET;
      r.now = ($urandom_range(19) == 0) ? $urandom : sim_ms;
      if ($urandom_range(9) != 0) r.delay = $urandom_range(300);
      sel = $urandom_range(9);
      if (sel < 4) r.period = 32'd0;
      else if (sel < 9) r.period = $urandom_range(200, 1);
    end else if (sel < 65) begin
      r.kind = att_pkg::KIND_DELETE;
      sel = $urandom_range(9);
      if (sel < 8) r.slot_handle = 9'($urandom_range(att_pkg::NUM_TIMERS - 1));
      else if (sel == 8) r.slot_handle = att_pkg::SLOT_HANDLE_NONE;
    end else if (sel < 95) begin
      r.kind = att_pkg::KIND_DISPATCH;
      sim_ms = sim_ms + $urandom_range(150);
      r.now = ($urandom_range(19) == 0) ? $urandom : sim_ms;
    end else begin
      r.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  task automatic run_phase(input logic [15:0] wait_setting, input logic [31:0] start_ms,
                           input int pct, input bit hold_off);
    alarm_req_t r;
    int sent;
    wait_for_results();
    cfg_data <= wait_setting;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    idle_pct = pct;
    stall_pct = pct;
    sim_ms = start_ms;
    if (hold_off) hold_off_req = 1'b1;
    for (int s = 0; s < att_pkg::NUM_TIMERS; s++) begin
      r = '0;
      r.kind = att_pkg::KIND_DELETE;
      r.slot_handle = 9'(s);
      send_request(r, 1'b1, att_pkg::RK_DELETED, 5'(s), 32'd0);
    end
    r = '0;
    r.kind = att_pkg::KIND_DISPATCH;
    r.now = sim_ms;
    send_request(r, 1'b1, att_pkg::RK_WAIT, att_pkg::HANDLE_NONE, {16'd0, wait_setting});
    sent = 0;
    while (sent < RANDOM_PER_PHASE) begin
      r = random_request();
      send_request(r, 1'b0, att_pkg::RK_SET_OK, att_pkg::HANDLE_NONE, 32'd0);
      if (r.kind != KIND_UNUSED) sent++;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 16'd0;
    in_valid = 1'b0;
    kind = att_pkg::KIND_SET;
    now = 32'd0;
    alarm_id = 32'd0;
    delay = 32'd0;
    period = 32'd0;
    slot_handle = 9'd0;
    typed_check = 1'b0;
    typed_kind = att_pkg::RK_SET_OK;
    typed_handle = att_pkg::HANDLE_NONE;
    typed_wait = 32'd0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].count)
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].t_kind,
                     directed_rows[i].t_handle, directed_rows[i].t_wait);
    end

    run_phase(16'hFFFF, 32'($urandom_range(1000)), 8, 1'b0);
    run_phase(16'h0000, 32'($urandom_range(1000)), 0, 1'b0);
    run_phase(16'($urandom), 32'hFFFFF000, 8, 1'b1);
    run_phase(16'd1, $urandom, 8, 1'b0);

    wait_for_results();
    $display("Run covered %0d requests over four idle_wait settings, including a full table.",
             accepted_count);
    $display("%0d results checked, %0d of them fired alarms and %0d table-full reports.",
             checked_count, fired_count, full_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/att_pkg.sv
hdl/att_alu.sv
hdl/alarm_timer_table_top.sv
sim/testbench.sv
